@@ hw/rtl/small_matrix_multiply_engine_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Small matrix multiply engine: assertion macros
// Shared concurrent assertion forms, sampled on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef SMALL_MATRIX_MULTIPLY_ENGINE_UNIT_DEFINES_SVH
`define SMALL_MATRIX_MULTIPLY_ENGINE_UNIT_DEFINES_SVH

// same-cycle implication
`define SMME_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SMME_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/smme_pkg.sv @@
// ----------------------------------------------------------------------------
// smme_pkg
// Types, constants and helpers shared by the matrix multiply engine.
// ----------------------------------------------------------------------------
package smme_pkg;

  localparam int MAX_DIM   = 8;
  localparam int IDX_W     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DEPTH     = MAX_DIM * MAX_DIM;
  localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam int MODE_W    = 2;
  localparam int FIELD_W   = 3;
  localparam int ELEM_W    = 16;
  localparam int PROD_W    = 32;
  localparam int SUM_W     = 40;
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 2;

  localparam int CMD_DEPTH = 2;
  localparam int CMD_PTR_W = 1;
  localparam int CMD_CNT_W = 2;
  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = 2;
  localparam int OUT_CNT_W = 3;

  localparam logic [MODE_W-1:0] MODE_WR_A    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WR_B    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_COMPUTE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_LEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 2'd2;

  typedef enum logic [1:0] {
    OP_WR_A,
    OP_WR_B,
    OP_COMPUTE
  } smme_op_e;

  typedef struct packed {
    smme_op_e                 op;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [ELEM_W-1:0] value;
    logic [IDX_W-1:0]         rows_last;
    logic [IDX_W-1:0]         inner_last;
    logic [IDX_W-1:0]         cols_last;
  } smme_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } smme_q_stat_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic                    last;
  } smme_res_t;

  // size register to last index in use: 0 acts as 1, above MAX_DIM clamps
  function automatic logic [IDX_W-1:0] smme_dim_last(input logic [CFG_W-1:0] v);
    logic [IDX_W-1:0] res;
    if (v == '0) begin
      res = '0;
    end else if (v > CFG_W'(MAX_DIM)) begin
      res = IDX_W'(MAX_DIM - 1);
    end else begin
      res = IDX_W'(v - 1'b1);
    end
    return res;
  endfunction

  function automatic logic [ADDR_W-1:0] smme_addr(input logic [IDX_W-1:0] row,
                                                   input logic [IDX_W-1:0] col);
    return ADDR_W'(int'(row) * MAX_DIM + int'(col));
  endfunction

endpackage

@@ hw/rtl/smme_front.sv @@
// ----------------------------------------------------------------------------
// smme_front
// Holds the size registers, decodes input items into commands for the queue.
// ----------------------------------------------------------------------------
module smme_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push_i,
  input  logic [smme_pkg::MODE_W-1:0]       mode_i,
  input  logic [smme_pkg::FIELD_W-1:0]      row_index_i,
  input  logic [smme_pkg::FIELD_W-1:0]      col_index_i,
  input  logic signed [smme_pkg::ELEM_W-1:0] elem_value_i,
  input  logic                              cfg_we_i,
  input  logic [smme_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [smme_pkg::CFG_W-1:0]        cfg_wdata_i,
  input  smme_pkg::smme_q_stat_t            q_stat_i,
  output logic                              full_o,
  output logic                              cmd_push_o,
  output smme_pkg::smme_cmd_t               cmd_o
);
  import smme_pkg::*;

  logic [IDX_W-1:0] rows_last_q, rows_last_d;
  logic [IDX_W-1:0] inner_last_q, inner_last_d;
  logic [IDX_W-1:0] cols_last_q, cols_last_d;
  logic             in_range;
  logic             keep;
  smme_op_e         op;

  always_comb begin
    rows_last_d  = rows_last_q;
    inner_last_d = inner_last_q;
    cols_last_d  = cols_last_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ROWS_A:    rows_last_d  = smme_dim_last(cfg_wdata_i);
        CFG_INNER_LEN: inner_last_d = smme_dim_last(cfg_wdata_i);
        CFG_COLS_B:    cols_last_d  = smme_dim_last(cfg_wdata_i);
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_last_q  <= '0;
      inner_last_q <= '0;
      cols_last_q  <= '0;
    end else begin
      rows_last_q  <= rows_last_d;
      inner_last_q <= inner_last_d;
      cols_last_q  <= cols_last_d;
    end
  end

  assign in_range = (int'(row_index_i) < MAX_DIM) && (int'(col_index_i) < MAX_DIM);

  always_comb begin
    unique case (mode_i)
      MODE_WR_A: begin
        op   = OP_WR_A;
        keep = in_range;
      end
      MODE_WR_B: begin
        op   = OP_WR_B;
        keep = in_range;
      end
      MODE_COMPUTE: begin
        op   = OP_COMPUTE;
        keep = 1'b1;
      end
      default: begin
        op   = OP_WR_A;
        keep = 1'b0;
      end
    endcase
  end

  assign full_o     = q_stat_i.full;
  assign cmd_push_o = push_i && !q_stat_i.full && keep;

  always_comb begin
    cmd_o            = '0;
    cmd_o.op         = op;
    cmd_o.row        = IDX_W'(row_index_i);
    cmd_o.col        = IDX_W'(col_index_i);
    cmd_o.value      = elem_value_i;
    cmd_o.rows_last  = rows_last_q;
    cmd_o.inner_last = inner_last_q;
    cmd_o.cols_last  = cols_last_q;
  end

endmodule

@@ hw/rtl/smme_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// smme_cmd_fifo
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module smme_cmd_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  smme_pkg::smme_cmd_t    cmd_i,
  input  logic                   pop_i,
  output smme_pkg::smme_cmd_t    cmd_o,
  output smme_pkg::smme_q_stat_t stat_o
);
  import smme_pkg::*;

  smme_cmd_t            mem_q [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [CMD_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CMD_CNT_W-1:0] cnt_q, cnt_d;
  logic                 do_push;
  logic                 do_pop;

  assign stat_o.full  = (cnt_q == CMD_CNT_W'(CMD_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign cmd_o        = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) begin
      wr_ptr_d = (int'(wr_ptr_q) == CMD_DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (int'(rd_ptr_q) == CMD_DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
    end
    cnt_d = cnt_q + CMD_CNT_W'(do_push) - CMD_CNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

@@ hw/rtl/smme_back.sv @@
// ----------------------------------------------------------------------------
// smme_back
// Runs commands: element writes into the A and B stores, and the
// multiply-accumulate sequence of a compute, into a small result queue.
// ----------------------------------------------------------------------------
module smme_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  smme_pkg::smme_q_stat_t q_stat_i,
  input  smme_pkg::smme_cmd_t    cmd_i,
  output logic                   cmd_pop_o,
  input  logic                   pop_i,
  output logic                   empty_o,
  output smme_pkg::smme_res_t    res_o
);
  import smme_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } smme_state_e;

  typedef struct packed {
    logic             first;
    logic             last;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             last_elem;
  } smme_tag_t;

  smme_state_e      state_q, state_d;
  logic [IDX_W-1:0] r_q, r_d, c_q, c_d, k_q, k_d;
  logic [IDX_W-1:0] nr_q, nr_d, nk_q, nk_d, nc_q, nc_d;
  logic [OUT_CNT_W-1:0] credit_q, credit_d;

  logic issue;
  logic start;
  logic wr_a;
  logic wr_b;
  logic [ADDR_W-1:0] w_addr, a_addr, b_addr;

  logic signed [ELEM_W-1:0] a_mem [DEPTH];
  logic signed [ELEM_W-1:0] b_mem [DEPTH];
  logic signed [ELEM_W-1:0] a_rd_q, b_rd_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [SUM_W-1:0]  acc_q, acc_d;
  smme_tag_t                tag, s1_tag_q, s2_tag_q;
  logic                     s1_vld_q, s2_vld_q;

  smme_res_t            out_mem_q [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] out_wr_q, out_wr_d, out_rd_q, out_rd_d;
  logic [OUT_CNT_W-1:0] out_cnt_q, out_cnt_d;
  logic                 out_push;
  logic                 out_pop;
  smme_res_t            out_entry;

  // command issue and element sequencing
  assign cmd_pop_o = (state_q == ST_IDLE) && !q_stat_i.empty;
  assign wr_a      = cmd_pop_o && (cmd_i.op == OP_WR_A);
  assign wr_b      = cmd_pop_o && (cmd_i.op == OP_WR_B);
  assign issue     = (state_q == ST_RUN) && ((k_q != '0) || (credit_q != '0));
  assign start     = issue && (k_q == '0);

  assign w_addr = smme_addr(cmd_i.row, cmd_i.col);
  assign a_addr = smme_addr(r_q, k_q);
  assign b_addr = smme_addr(k_q, c_q);

  always_comb begin
    state_d = state_q;
    r_d     = r_q;
    c_d     = c_q;
    k_d     = k_q;
    nr_d    = nr_q;
    nk_d    = nk_q;
    nc_d    = nc_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_pop_o && (cmd_i.op == OP_COMPUTE)) begin
          nr_d    = cmd_i.rows_last;
          nk_d    = cmd_i.inner_last;
          nc_d    = cmd_i.cols_last;
          r_d     = '0;
          c_d     = '0;
          k_d     = '0;
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (issue) begin
          if (k_q != nk_q) begin
            k_d = k_q + 1'b1;
          end else begin
            k_d = '0;
            if (c_q != nc_q) begin
              c_d = c_q + 1'b1;
            end else begin
              c_d = '0;
              if (r_q != nr_q) begin
                r_d = r_q + 1'b1;
              end else begin
                state_d = ST_IDLE;
              end
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    tag.first     = (k_q == '0);
    tag.last      = (k_q == nk_q);
    tag.row       = r_q;
    tag.col       = c_q;
    tag.last_elem = (r_q == nr_q) && (c_q == nc_q);
  end

  // one result slot is reserved per element started
  assign credit_d = credit_q - OUT_CNT_W'(start) + OUT_CNT_W'(out_pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      r_q      <= '0;
      c_q      <= '0;
      k_q      <= '0;
      nr_q     <= '0;
      nk_q     <= '0;
      nc_q     <= '0;
      credit_q <= OUT_CNT_W'(OUT_DEPTH);
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      r_q      <= r_d;
      c_q      <= c_d;
      k_q      <= k_d;
      nr_q     <= nr_d;
      nk_q     <= nk_d;
      nc_q     <= nc_d;
      credit_q <= credit_d;
      s1_vld_q <= issue;
      s2_vld_q <= s1_vld_q;
    end
  end

  // operand stores
  always_ff @(posedge clk_i) begin
    if (wr_a) begin
      a_mem[w_addr] <= cmd_i.value;
    end
    if (wr_b) begin
      b_mem[w_addr] <= cmd_i.value;
    end
    if (issue) begin
      a_rd_q   <= a_mem[a_addr];
      b_rd_q   <= b_mem[b_addr];
      s1_tag_q <= tag;
    end
  end

  // multiply, then accumulate
  assign acc_d = s2_tag_q.first ? SUM_W'(prod_q) : acc_q + SUM_W'(prod_q);

  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      prod_q   <= a_rd_q * b_rd_q;
      s2_tag_q <= s1_tag_q;
    end
    if (s2_vld_q) begin
      acc_q <= acc_d;
    end
  end

  // result queue
  assign out_push = s2_vld_q && s2_tag_q.last;
  assign empty_o  = (out_cnt_q == '0);
  assign out_pop  = pop_i && !empty_o;
  assign res_o    = out_mem_q[out_rd_q];

  always_comb begin
    out_entry.sum  = acc_d;
    out_entry.row  = s2_tag_q.row;
    out_entry.col  = s2_tag_q.col;
    out_entry.last = s2_tag_q.last_elem;
    out_wr_d       = out_push ? out_wr_q + 1'b1 : out_wr_q;
    out_rd_d       = out_pop ? out_rd_q + 1'b1 : out_rd_q;
    out_cnt_d      = out_cnt_q + OUT_CNT_W'(out_push) - OUT_CNT_W'(out_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_wr_q  <= '0;
      out_rd_q  <= '0;
      out_cnt_q <= '0;
    end else begin
      out_wr_q  <= out_wr_d;
      out_rd_q  <= out_rd_d;
      out_cnt_q <= out_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_push) begin
      out_mem_q[out_wr_q] <= out_entry;
    end
  end

endmodule

@@ hw/rtl/small_matrix_multiply_engine_unit.sv @@
// ----------------------------------------------------------------------------
// small_matrix_multiply_engine_unit
// Stored-operand matrix multiply C = A * B on signed Q8.8, Q24.16 results.
// ----------------------------------------------------------------------------
// Element writes pass through a two-entry command queue and are stored by
// the back end as it pops them. A compute runs a single 16x16 multiplier
// and a 40-bit accumulator, one product per cycle while result slots are
// free; each result element sums inner_len products and is written to the
// result queue from the accumulator input after the operand read and
// product registers. Results wait in a four-entry queue; when all its slots
// are reserved, the multiply sequence pauses at the next element boundary.
// Commands queued behind a compute wait until its last product has issued.
`include "small_matrix_multiply_engine_unit_defines.svh"

module small_matrix_multiply_engine_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push_i,
  output logic                                full_o,
  input  logic [smme_pkg::MODE_W-1:0]         mode_i,
  input  logic [smme_pkg::FIELD_W-1:0]        row_index_i,
  input  logic [smme_pkg::FIELD_W-1:0]        col_index_i,
  input  logic signed [smme_pkg::ELEM_W-1:0]  elem_value_i,
  output logic                                empty_o,
  input  logic                                pop_i,
  output logic signed [smme_pkg::SUM_W-1:0]   sum_value_o,
  output logic [smme_pkg::FIELD_W-1:0]        out_row_o,
  output logic [smme_pkg::FIELD_W-1:0]        out_col_o,
  output logic                                last_elem_o,
  input  logic                                cfg_we_i,
  input  logic [smme_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [smme_pkg::CFG_W-1:0]          cfg_wdata_i
);
  import smme_pkg::*;

  logic         cmd_push;
  logic         cmd_pop;
  smme_cmd_t    cmd_in;
  smme_cmd_t    cmd_out;
  smme_q_stat_t q_stat;
  smme_res_t    res;

  smme_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_i),
    .mode_i      (mode_i),
    .row_index_i (row_index_i),
    .col_index_i (col_index_i),
    .elem_value_i(elem_value_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_stat_i    (q_stat),
    .full_o      (full_o),
    .cmd_push_o  (cmd_push),
    .cmd_o       (cmd_in)
  );

  smme_cmd_fifo u_cmd_fifo (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(cmd_push),
    .cmd_i (cmd_in),
    .pop_i (cmd_pop),
    .cmd_o (cmd_out),
    .stat_o(q_stat)
  );

  smme_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_stat_i (q_stat),
    .cmd_i    (cmd_out),
    .cmd_pop_o(cmd_pop),
    .pop_i    (pop_i),
    .empty_o  (empty_o),
    .res_o    (res)
  );

  assign sum_value_o = res.sum;
  assign out_row_o   = FIELD_W'(res.row);
  assign out_col_o   = FIELD_W'(res.col);
  assign last_elem_o = res.last;

  `SMME_ASSERT_NEXT(a_compute_queued, push_i && !full_o && (mode_i == MODE_COMPUTE), !q_stat.empty, "accepted compute did not reach the command queue")
  `SMME_ASSERT_NOW(a_unused_mode_dropped, push_i && (mode_i != MODE_WR_A) && (mode_i != MODE_WR_B) && (mode_i != MODE_COMPUTE), !cmd_push, "unused mode entered the command queue")
  `SMME_ASSERT_NOW(a_pop_nonempty, cmd_pop, !q_stat.empty, "back end took a command from an empty queue")

endmodule

@@ test/tb_small_matrix_multiply_engine_unit.sv @@
// ----------------------------------------------------------------------------
// tb_small_matrix_multiply_engine_unit
// Self-checking bench for the stored-operand matrix multiply engine. Element
// writes and compute requests are driven through the push/full side with
// random gaps. Every result element popped is checked against an in-bench
// prediction of C = A * B over the current size registers. Size registers
// are rewritten between phases, including zero and over-range values.
// ----------------------------------------------------------------------------
module tb_small_matrix_multiply_engine_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import smme_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int IDLE_LIMIT    = 4000;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_ITEMS  = 160;
  localparam int MAX_SHOWN     = 30;

  typedef struct {
    logic [MODE_W-1:0]        mode;
    logic [FIELD_W-1:0]       row;
    logic [FIELD_W-1:0]       col;
    logic signed [ELEM_W-1:0] value;
  } elem_req_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      push_i = 1'b0;
  logic                      full_o;
  logic [MODE_W-1:0]         mode_i = '0;
  logic [FIELD_W-1:0]        row_index_i = '0;
  logic [FIELD_W-1:0]        col_index_i = '0;
  logic signed [ELEM_W-1:0]  elem_value_i = '0;
  logic                      empty_o;
  logic                      pop_i = 1'b0;
  logic signed [SUM_W-1:0]   sum_value_o;
  logic [FIELD_W-1:0]        out_row_o;
  logic [FIELD_W-1:0]        out_col_o;
  logic                      last_elem_o;
  logic                      cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_idx_i = '0;
  logic [CFG_W-1:0]          cfg_wdata_i = '0;

  small_matrix_multiply_engine_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_i),
    .full_o      (full_o),
    .mode_i      (mode_i),
    .row_index_i (row_index_i),
    .col_index_i (col_index_i),
    .elem_value_i(elem_value_i),
    .empty_o     (empty_o),
    .pop_i       (pop_i),
    .sum_value_o (sum_value_o),
    .out_row_o   (out_row_o),
    .out_col_o   (out_col_o),
    .last_elem_o (last_elem_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // pending requests, predicted product elements
  elem_req_t req_fifo[$];
  smme_res_t products_due[$];

  // predictor state
  logic signed [ELEM_W-1:0] a_mat [DEPTH];
  logic signed [ELEM_W-1:0] b_mat [DEPTH];
  logic [CFG_W-1:0]         size_reg [3] = '{4'd1, 4'd1, 4'd1};

  // stimulus-side tracking of written elements and planned sizes
  bit gen_a_set [DEPTH];
  bit gen_b_set [DEPTH];
  int plan_r = 1;
  int plan_k = 1;
  int plan_c = 1;

  bit idle_on = 1'b1;
  int hold_seq = 0;
  int n_taken = 0;
  int n_items = 0;
  int n_computes = 0;
  int n_results = 0;
  int n_settings = 0;
  int n_errors = 0;

  function automatic int dim_of(logic [CFG_W-1:0] v);
    if (v == '0) begin
      return 1;
    end
    if (v > CFG_W'(MAX_DIM)) begin
      return MAX_DIM;
    end
    return int'(v);
  endfunction

  function automatic int rand_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) begin
      return 0;
    end else if (p < 85) begin
      return $urandom_range(1, 3);
    end else if (p < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [ELEM_W-1:0] rand_elem();
    case ($urandom_range(0, 19))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return '0;
      3: return '1;
      default: return ELEM_W'($urandom());
    endcase
  endfunction

  // applies one accepted request; a compute queues its product elements
  function automatic void predict_products(elem_req_t rq);
    int nr, nk, nc;
    longint acc;
    smme_res_t res;
    case (rq.mode)
      MODE_WR_A: a_mat[int'(rq.row) * MAX_DIM + int'(rq.col)] = rq.value;
      MODE_WR_B: b_mat[int'(rq.row) * MAX_DIM + int'(rq.col)] = rq.value;
      MODE_COMPUTE: begin
        nr = dim_of(size_reg[CFG_ROWS_A]);
        nk = dim_of(size_reg[CFG_INNER_LEN]);
        nc = dim_of(size_reg[CFG_COLS_B]);
        for (int r = 0; r < nr; r++) begin
          for (int c = 0; c < nc; c++) begin
            acc = 0;
            for (int k = 0; k < nk; k++) begin
              acc += longint'(a_mat[r * MAX_DIM + k]) * longint'(b_mat[k * MAX_DIM + c]);
            end
            res.sum  = acc[SUM_W-1:0];
            res.row  = IDX_W'(r);
            res.col  = IDX_W'(c);
            res.last = (r == nr - 1) && (c == nc - 1);
            products_due.push_back(res);
          end
        end
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
    n_errors++;
    if (n_errors <= MAX_SHOWN) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
    end
  endtask

  // request accept and prediction
  always @(posedge clk_i) begin
    if (rst_ni && push_i && !full_o && req_fifo.size() != 0) begin
      predict_products(req_fifo.pop_front());
      n_taken++;
    end
  end

  // request driver
  int gap_left = 0;
  int taken_seen = 0;
  always @(negedge clk_i) begin
    if (n_taken != taken_seen) begin
      taken_seen = n_taken;
      gap_left = idle_on ? rand_gap() : 0;
    end
    if (!rst_ni || gap_left > 0 || req_fifo.size() == 0) begin
      push_i <= 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end
    end else begin
      push_i       <= 1'b1;
      mode_i       <= req_fifo[0].mode;
      row_index_i  <= req_fifo[0].row;
      col_index_i  <= req_fifo[0].col;
      elem_value_i <= req_fifo[0].value;
    end
  end

  // result receiver: random stalls plus the long hold-off on request
  int hold_left = 0;
  int hold_seen = 0;
  always @(negedge clk_i) begin
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      pop_i <= 1'b0;
      hold_left--;
    end else if (idle_on && $urandom_range(0, 99) < 25) begin
      hold_left = rand_gap();
      pop_i <= 1'b0;
    end else begin
      pop_i <= 1'b1;
    end
  end

  // result checker
  smme_res_t want;
  always @(posedge clk_i) begin
    if (rst_ni && pop_i && !empty_o) begin
      n_results++;
      if (products_due.size() == 0) begin
        report_mismatch("unexpected result sum", '0, sum_value_o);
      end else begin
        want = products_due.pop_front();
        if (sum_value_o !== want.sum) begin
          report_mismatch("sum_value", want.sum, sum_value_o);
        end
        if (out_row_o !== want.row) begin
          report_mismatch("out_row", want.row, out_row_o);
        end
        if (out_col_o !== want.col) begin
          report_mismatch("out_col", want.col, out_col_o);
        end
        if (last_elem_o !== want.last) begin
          report_mismatch("last_elem", want.last, last_elem_o);
        end
      end
    end
  end

  // watchdog on cycles without any accepted transfer
  int stall_count = 0;
  always @(posedge clk_i) begin
    if ((push_i && !full_o) || (pop_i && !empty_o) || cfg_we_i) begin
      stall_count = 0;
    end else begin
      stall_count++;
      if (stall_count >= IDLE_LIMIT) begin
        $display("tb_small_matrix_multiply_engine_unit: FAIL");
        $finish;
      end
    end
  end

  task automatic add_req(logic [MODE_W-1:0] m, logic [FIELD_W-1:0] r, logic [FIELD_W-1:0] c,
                         logic signed [ELEM_W-1:0] v);
    req_fifo.push_back('{mode: m, row: r, col: c, value: v});
    case (m)
      MODE_WR_A: gen_a_set[int'(r) * MAX_DIM + int'(c)] = 1'b1;
      MODE_WR_B: gen_b_set[int'(r) * MAX_DIM + int'(c)] = 1'b1;
      MODE_COMPUTE: n_computes++;
      default: ;
    endcase
    if (m != MODE_UNUSED) begin
      n_items++;
    end
  endtask

  // write to A or B, mostly inside the region in use
  task automatic add_write(logic [MODE_W-1:0] m);
    int rmax, cmax;
    rmax = (m == MODE_WR_A) ? plan_r : plan_k;
    cmax = (m == MODE_WR_A) ? plan_k : plan_c;
    if ($urandom_range(0, 99) < 75) begin
      add_req(m, FIELD_W'($urandom_range(0, rmax - 1)), FIELD_W'($urandom_range(0, cmax - 1)),
              rand_elem());
    end else begin
      add_req(m, FIELD_W'($urandom_range(0, 7)), FIELD_W'($urandom_range(0, 7)), rand_elem());
    end
  endtask

  // fill any element the compute would read that was never written, then queue the compute
  task automatic add_compute();
    for (int r = 0; r < plan_r; r++) begin
      for (int k = 0; k < plan_k; k++) begin
        if (!gen_a_set[r * MAX_DIM + k]) begin
          add_req(MODE_WR_A, FIELD_W'(r), FIELD_W'(k), rand_elem());
        end
      end
    end
    for (int k = 0; k < plan_k; k++) begin
      for (int c = 0; c < plan_c; c++) begin
        if (!gen_b_set[k * MAX_DIM + c]) begin
          add_req(MODE_WR_B, FIELD_W'(k), FIELD_W'(c), rand_elem());
        end
      end
    end
    add_req(MODE_COMPUTE, FIELD_W'($urandom_range(0, 7)), FIELD_W'($urandom_range(0, 7)),
            ELEM_W'($urandom()));
  endtask

  task automatic wait_idle();
    while (req_fifo.size() != 0) begin
      @(posedge clk_i);
    end
    while (products_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_sizes(logic [CFG_W-1:0] r, logic [CFG_W-1:0] k, logic [CFG_W-1:0] c);
    wait_idle();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_ROWS_A;
    cfg_wdata_i <= r;
    @(negedge clk_i);
    cfg_idx_i   <= CFG_INNER_LEN;
    cfg_wdata_i <= k;
    @(negedge clk_i);
    cfg_idx_i   <= CFG_COLS_B;
    cfg_wdata_i <= c;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    size_reg[CFG_ROWS_A]    = r;
    size_reg[CFG_INNER_LEN] = k;
    size_reg[CFG_COLS_B]    = c;
    plan_r = dim_of(r);
    plan_k = dim_of(k);
    plan_c = dim_of(c);
    n_settings++;
  endtask

  function automatic logic [CFG_W-1:0] rand_size();
    int p;
    p = $urandom_range(0, 99);
    if (p < 8) begin
      return '0;
    end else if (p < 16) begin
      return CFG_W'($urandom_range(MAX_DIM + 1, 15));
    end else if (p < 24) begin
      return CFG_W'(MAX_DIM);
    end
    return CFG_W'($urandom_range(1, 4));
  endfunction

  initial begin
    int base;
    int nreq;
    int p;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: operand extremes at reset sizes, ignored mode, far corner
    add_req(MODE_WR_A, 3'd0, 3'd0, 16'sh8000);
    add_req(MODE_WR_B, 3'd0, 3'd0, 16'sh8000);
    add_req(MODE_COMPUTE, 3'd0, 3'd0, '0);
    add_req(MODE_WR_B, 3'd0, 3'd0, 16'sh7fff);
    add_req(MODE_COMPUTE, 3'd7, 3'd7, '1);
    add_req(MODE_UNUSED, 3'd7, 3'd7, 16'sh5a5a);
    add_req(MODE_WR_A, 3'd7, 3'd7, 16'sh7fff);
    add_req(MODE_WR_B, 3'd7, 3'd7, '1);
    add_req(MODE_WR_A, 3'd0, 3'd0, 16'sh7fff);
    add_req(MODE_COMPUTE, 3'd0, 3'd0, '0);

    // largest sum: eight products of the most negative value
    set_sizes(4'd1, 4'd8, 4'd1);
    for (int k = 0; k < MAX_DIM; k++) begin
      add_req(MODE_WR_A, 3'd0, FIELD_W'(k), 16'sh8000);
      add_req(MODE_WR_B, FIELD_W'(k), 3'd0, 16'sh8000);
    end
    add_compute();

    // zero and over-range size registers, then full size
    set_sizes(4'd0, 4'd15, 4'd9);
    add_compute();
    set_sizes(4'd15, 4'd0, 4'd0);
    add_compute();
    set_sizes(4'd8, 4'd8, 4'd8);
    add_compute();

    // random phases
    base = n_items;
    while (n_items - base < RANDOM_ITEMS) begin
      set_sizes(rand_size(), rand_size(), rand_size());
      idle_on = ($urandom_range(0, 3) != 0);
      nreq = $urandom_range(8, 30);
      for (int i = 0; i < nreq; i++) begin
        p = $urandom_range(0, 99);
        if (p < 6) begin
          add_req(MODE_UNUSED, FIELD_W'($urandom()), FIELD_W'($urandom()), ELEM_W'($urandom()));
        end else if (p < 46) begin
          add_write(MODE_WR_A);
        end else if (p < 84) begin
          add_write(MODE_WR_B);
        end else begin
          add_compute();
        end
      end
      add_compute();
    end

    // receiver holds off while computes keep coming, so the input stalls
    set_sizes(4'd2, 4'd2, 4'd2);
    idle_on = 1'b1;
    hold_seq++;
    for (int i = 0; i < 10; i++) begin
      add_write(($urandom_range(0, 1) != 0) ? MODE_WR_A : MODE_WR_B);
      add_compute();
    end
    wait_idle();

    $display("covered %0d requests, %0d computes, %0d size settings",
             n_items, n_computes, n_settings);
    $display("checked %0d result elements, %0d mismatches", n_results, n_errors);
    if (n_errors == 0) begin
      $display("tb_small_matrix_multiply_engine_unit: PASS");
    end else begin
      $display("tb_small_matrix_multiply_engine_unit: FAIL");
    end
    $finish;
  end

endmodule
